FILE: hw/rtl/vmap_pkg.sv
`timescale 1ns / 1ps
package vmap_pkg;

  // table geometry
  localparam int TABLE_ENTRIES = 4096;
  localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
  localparam int MAX_POINTS    = 32;
  localparam int IDX_W         = $clog2(MAX_POINTS);
  localparam int PTS_W         = $clog2(MAX_POINTS + 1);
  localparam int PADDR_W       = SLOT_W + IDX_W;
  localparam int COORD_W       = 24;
  localparam int PROBE_LIMIT   = 8;
  localparam int PROBE_W       = $clog2(PROBE_LIMIT + 1);

  // counters and arithmetic
  localparam int VCNT_W  = 13;
  localparam int PCNT_W  = 18;
  localparam int SQ_W    = 2 * (COORD_W + 1);
  localparam int DSUM_W  = SQ_W + 2;
  localparam int CFG_W   = 50;
  localparam int CADDR_W = 2;

  // hash multipliers
  localparam logic [31:0] HASH_X = 32'd73856093;
  localparam logic [31:0] HASH_Y = 32'd19349669;
  localparam logic [31:0] HASH_Z = 32'd83492791;

  // register indexes
  localparam logic [CADDR_W-1:0] CFG_SHIFT   = 2'd0;
  localparam logic [CADDR_W-1:0] CFG_LIMIT   = 2'd1;
  localparam logic [CADDR_W-1:0] CFG_SPACING = 2'd2;
  localparam logic [CADDR_W-1:0] CFG_MAXDIST = 2'd3;

  // function codes; the high bit alone selects clear
  localparam logic [1:0] FUNC_ADD   = 2'd0;
  localparam logic [1:0] FUNC_PRUNE = 2'd1;

  typedef enum logic [2:0] {
    ST_APPENDED   = 3'd0,
    ST_NEW_VOXEL  = 3'd1,
    ST_FULL       = 3'd2,
    ST_TOO_CLOSE  = 3'd3,
    ST_NOT_FINITE = 3'd4,
    ST_TABLE_FULL = 3'd5,
    ST_PRUNED     = 3'd6,
    ST_CLEARED    = 3'd7
  } status_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  typedef struct packed {
    logic               valid;
    logic [COORD_W-1:0] kx;
    logic [COORD_W-1:0] ky;
    logic [COORD_W-1:0] kz;
    logic [PTS_W-1:0]   pts;
  } entry_t;

  // floor shift of a coordinate to its voxel key
  function automatic logic [COORD_W-1:0] voxel_key(input logic signed [COORD_W-1:0] v,
                                                   input logic [4:0] sh);
    logic signed [COORD_W-1:0] k;
    k = v >>> sh;
    return k;
  endfunction

  // only the low slot bits of each product reach the table index
  function automatic logic [SLOT_W-1:0] home_slot(input logic [COORD_W-1:0] kx,
                                                  input logic [COORD_W-1:0] ky,
                                                  input logic [COORD_W-1:0] kz);
    logic [2*SLOT_W-1:0] px;
    logic [2*SLOT_W-1:0] py;
    logic [2*SLOT_W-1:0] pz;
    px = kx[SLOT_W-1:0] * HASH_X[SLOT_W-1:0];
    py = ky[SLOT_W-1:0] * HASH_Y[SLOT_W-1:0];
    pz = kz[SLOT_W-1:0] * HASH_Z[SLOT_W-1:0];
    return px[SLOT_W-1:0] ^ py[SLOT_W-1:0] ^ pz[SLOT_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/vmap_ram.sv
`timescale 1ns / 1ps
module vmap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/vmap_dist.sv
`timescale 1ns / 1ps
module vmap_dist (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  vmap_pkg::point_t             a,
  input  vmap_pkg::point_t             b,
  output logic                         out_valid,
  output logic [vmap_pkg::DSUM_W-1:0]  dsum,
  output logic                         busy
);

  logic signed [vmap_pkg::COORD_W:0]   dx, dy, dz;
  logic signed [vmap_pkg::SQ_W-1:0]    sx, sy, sz;
  logic [vmap_pkg::SQ_W-1:0]           sqx_r, sqy_r, sqz_r;
  logic                                v1_r;

  // per-axis difference and square
  always_comb begin
    dx = {a.x[vmap_pkg::COORD_W-1], a.x} - {b.x[vmap_pkg::COORD_W-1], b.x};
    dy = {a.y[vmap_pkg::COORD_W-1], a.y} - {b.y[vmap_pkg::COORD_W-1], b.y};
    dz = {a.z[vmap_pkg::COORD_W-1], a.z} - {b.z[vmap_pkg::COORD_W-1], b.z};
    sx = dx * dx;
    sy = dy * dy;
    sz = dz * dz;
  end

  // square stage, then sum stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1_r      <= in_valid;
      out_valid <= v1_r;
    end
    sqx_r <= sx;
    sqy_r <= sy;
    sqz_r <= sz;
    dsum  <= vmap_pkg::DSUM_W'(sqx_r) + vmap_pkg::DSUM_W'(sqy_r)
           + vmap_pkg::DSUM_W'(sqz_r);
  end

  assign busy = v1_r | out_valid;

endmodule

FILE: hw/rtl/voxel_map_point_insert_prune.sv
`timescale 1ns / 1ps
// add: a new voxel, a full voxel or a full table is reported once the probes end,
// an append only after each stored point of the voxel has been compared
// prune: one pass over all 4096 slots, occupied slots also going through the distance unit
// clear: one table slot written a cycle; one transaction at a time
// reset: synchronous, starts a clearing pass of the voxel table,
// in_tready stays low until it ends; point storage is never cleared
module voxel_map_point_insert_prune (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [71:0]                      in_tdata,   // x_coord, y_coord, z_coord
  input  logic [2:0]                       in_tuser,   // func, point_finite
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [47:0]                      out_tdata,  // removed_voxels, occupied_voxels,
                                                       // total_points, zero pad
  output logic [2:0]                       out_tuser,  // status
  input  logic                             cfg_we,
  input  logic [vmap_pkg::CADDR_W-1:0]     cfg_addr,
  input  logic [vmap_pkg::CFG_W-1:0]       cfg_wdata
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_KEY, S_PROBE, S_DECIDE, S_SCAN,
    S_PR_RD, S_PR_ENT, S_PR_DST, S_PR_WAIT, S_RESULT
  } state_t;

  localparam int SW = vmap_pkg::SLOT_W;
  localparam int IW = vmap_pkg::IDX_W;
  localparam int PW = vmap_pkg::PTS_W;

  state_t                          state_r;
  logic [4:0]                      shift_r;
  logic [5:0]                      limit_r;
  logic [vmap_pkg::CFG_W-1:0]      minsp_r, maxd_r;
  vmap_pkg::point_t                p_r;
  logic [vmap_pkg::COORD_W-1:0]    kx_r, ky_r, kz_r;
  logic [SW-1:0]                   home_r, pe_slot_r, hit_r, free_r, clr_idx_r, pr_idx_r;
  logic [vmap_pkg::PROBE_W-1:0]    pi_r;
  logic                            pe_v_r, found_r, have_free_r, clr_item_r;
  logic [PW-1:0]                   hit_pts_r, si_r, pr_pts_r;
  logic                            siss_v_r, close_r;
  vmap_pkg::status_t               st_r, out_st_r;
  logic [vmap_pkg::VCNT_W-1:0]     vcnt_r, removed_r, out_rem_r, out_occ_r;
  logic [vmap_pkg::PCNT_W-1:0]     pcnt_r, out_tot_r;
  logic                            out_valid_r;

  logic                            ent_we, pt_we;
  logic [SW-1:0]                   ent_waddr, ent_raddr;
  vmap_pkg::entry_t                ent_wdata, ent_rdata;
  logic [vmap_pkg::PADDR_W-1:0]    pt_waddr, pt_raddr;
  vmap_pkg::point_t                pt_rdata;
  logic                            siss, scan_done, dist_in_v, dist_ov, dist_busy;
  logic [vmap_pkg::DSUM_W-1:0]     dsum;
  logic                            near, far, key_match;
  logic [PW-1:0]                   lim;
  logic [SW-1:0]                   probe_addr;

  vmap_ram #(.WIDTH($bits(vmap_pkg::entry_t)), .DEPTH(vmap_pkg::TABLE_ENTRIES)) u_ent (
    .clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
    .raddr(ent_raddr), .rdata(ent_rdata)
  );

  vmap_ram #(.WIDTH($bits(vmap_pkg::point_t)),
             .DEPTH(vmap_pkg::TABLE_ENTRIES * vmap_pkg::MAX_POINTS)) u_pts (
    .clk(clk), .we(pt_we), .waddr(pt_waddr), .wdata(p_r),
    .raddr(pt_raddr), .rdata(pt_rdata)
  );

  vmap_dist u_dist (
    .clk(clk), .rst_n(rst_n), .in_valid(dist_in_v), .a(pt_rdata), .b(p_r),
    .out_valid(dist_ov), .dsum(dsum), .busy(dist_busy)
  );

  // decode helpers
  always_comb begin
    lim        = (limit_r > 6'(vmap_pkg::MAX_POINTS)) ? PW'(vmap_pkg::MAX_POINTS)
                                                       : PW'(limit_r);
    near       = dsum < vmap_pkg::DSUM_W'(minsp_r);
    far        = dsum >= vmap_pkg::DSUM_W'(maxd_r);
    key_match  = (ent_rdata.kx == kx_r) && (ent_rdata.ky == ky_r) && (ent_rdata.kz == kz_r);
    probe_addr = home_r + SW'(pi_r);
    siss       = (state_r == S_SCAN) && (si_r < hit_pts_r);
    scan_done  = (si_r == hit_pts_r) && !siss_v_r && !dist_busy;
    dist_in_v  = siss_v_r || (state_r == S_PR_DST);
  end

  // memory port control
  always_comb begin
    ent_we    = 1'b0;
    ent_waddr = clr_idx_r;
    ent_wdata = '0;
    ent_raddr = pr_idx_r;
    pt_we     = 1'b0;
    pt_waddr  = {free_r, IW'(0)};
    pt_raddr  = {pr_idx_r, IW'(0)};
    unique case (state_r)
      S_CLR: begin
        ent_we = 1'b1;
      end
      S_PROBE: begin
        ent_raddr = probe_addr;
      end
      S_DECIDE: begin
        if (!found_r && have_free_r) begin
          ent_we    = 1'b1;
          ent_waddr = free_r;
          ent_wdata = '{valid: 1'b1, kx: kx_r, ky: ky_r, kz: kz_r, pts: PW'(1)};
          pt_we     = 1'b1;
        end
      end
      S_SCAN: begin
        pt_raddr = {hit_r, si_r[IW-1:0]};
        if (scan_done && !close_r) begin
          ent_we    = 1'b1;
          ent_waddr = hit_r;
          ent_wdata = '{valid: 1'b1, kx: kx_r, ky: ky_r, kz: kz_r, pts: hit_pts_r + PW'(1)};
          pt_we     = 1'b1;
          pt_waddr  = {hit_r, hit_pts_r[IW-1:0]};
        end
      end
      S_PR_WAIT: begin
        if (dist_ov && far) begin
          ent_we    = 1'b1;
          ent_waddr = pr_idx_r;
        end
      end
      default: begin
      end
    endcase
  end

  // sequencer, counters and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_idx_r   <= '0;
      clr_item_r  <= 1'b0;
      out_valid_r <= 1'b0;
      vcnt_r      <= '0;
      pcnt_r      <= '0;
      shift_r     <= 5'd10;
      limit_r     <= 6'd20;
      minsp_r     <= vmap_pkg::CFG_W'(52429);
      maxd_r      <= vmap_pkg::CFG_W'(64'd10000000000);
      pe_v_r      <= 1'b0;
      siss_v_r    <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_we) begin
        unique case (cfg_addr)
          vmap_pkg::CFG_SHIFT:   shift_r <= cfg_wdata[4:0];
          vmap_pkg::CFG_LIMIT:   limit_r <= cfg_wdata[5:0];
          vmap_pkg::CFG_SPACING: minsp_r <= cfg_wdata;
          vmap_pkg::CFG_MAXDIST: maxd_r  <= cfg_wdata;
        endcase
      end

      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_CLR: begin
          clr_idx_r <= clr_idx_r + SW'(1);
          if (&clr_idx_r) begin
            st_r    <= vmap_pkg::ST_CLEARED;
            state_r <= clr_item_r ? S_RESULT : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_tvalid) begin
            p_r       <= '{x: in_tdata[23:0], y: in_tdata[47:24], z: in_tdata[71:48]};
            removed_r <= '0;
            pr_idx_r  <= '0;
            if (in_tuser[1]) begin
              clr_idx_r  <= '0;
              clr_item_r <= 1'b1;
              vcnt_r     <= '0;
              pcnt_r     <= '0;
              state_r    <= S_CLR;
            end else if (in_tuser[1:0] == vmap_pkg::FUNC_PRUNE) begin
              state_r <= S_PR_RD;
            end else if (!in_tuser[2]) begin
              st_r    <= vmap_pkg::ST_NOT_FINITE;
              state_r <= S_RESULT;
            end else begin
              state_r <= S_KEY;
            end
          end
        end
        S_KEY: begin
          kx_r        <= vmap_pkg::voxel_key(p_r.x, shift_r);
          ky_r        <= vmap_pkg::voxel_key(p_r.y, shift_r);
          kz_r        <= vmap_pkg::voxel_key(p_r.z, shift_r);
          home_r      <= vmap_pkg::home_slot(vmap_pkg::voxel_key(p_r.x, shift_r),
                                             vmap_pkg::voxel_key(p_r.y, shift_r),
                                             vmap_pkg::voxel_key(p_r.z, shift_r));
          pi_r        <= '0;
          pe_v_r      <= 1'b0;
          found_r     <= 1'b0;
          have_free_r <= 1'b0;
          state_r     <= S_PROBE;
        end
        S_PROBE: begin
          // issue one probe read, evaluate the previous one
          if (pi_r < vmap_pkg::PROBE_W'(vmap_pkg::PROBE_LIMIT)) begin
            pi_r      <= pi_r + vmap_pkg::PROBE_W'(1);
            pe_v_r    <= 1'b1;
            pe_slot_r <= probe_addr;
          end else begin
            pe_v_r <= 1'b0;
            if (!pe_v_r) begin
              state_r <= S_DECIDE;
            end
          end
          if (pe_v_r) begin
            if (ent_rdata.valid) begin
              if (!found_r && key_match) begin
                found_r   <= 1'b1;
                hit_r     <= pe_slot_r;
                hit_pts_r <= ent_rdata.pts;
              end
            end else if (!have_free_r) begin
              have_free_r <= 1'b1;
              free_r      <= pe_slot_r;
            end
          end
        end
        S_DECIDE: begin
          si_r     <= '0;
          close_r  <= 1'b0;
          siss_v_r <= 1'b0;
          if (!found_r) begin
            if (!have_free_r) begin
              st_r <= vmap_pkg::ST_TABLE_FULL;
            end else begin
              st_r   <= vmap_pkg::ST_NEW_VOXEL;
              vcnt_r <= vcnt_r + vmap_pkg::VCNT_W'(1);
              pcnt_r <= pcnt_r + vmap_pkg::PCNT_W'(1);
            end
            state_r <= S_RESULT;
          end else if (hit_pts_r >= lim) begin
            st_r    <= vmap_pkg::ST_FULL;
            state_r <= S_RESULT;
          end else begin
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          // stream stored points through the distance unit
          siss_v_r <= siss;
          if (siss) begin
            si_r <= si_r + PW'(1);
          end
          if (dist_ov && near) begin
            close_r <= 1'b1;
          end
          if (scan_done) begin
            if (close_r) begin
              st_r <= vmap_pkg::ST_TOO_CLOSE;
            end else begin
              st_r   <= vmap_pkg::ST_APPENDED;
              pcnt_r <= pcnt_r + vmap_pkg::PCNT_W'(1);
            end
            state_r <= S_RESULT;
          end
        end
        S_PR_RD: begin
          state_r <= S_PR_ENT;
        end
        S_PR_ENT: begin
          if (ent_rdata.valid) begin
            pr_pts_r <= ent_rdata.pts;
            state_r  <= S_PR_DST;
          end else if (&pr_idx_r) begin
            st_r    <= vmap_pkg::ST_PRUNED;
            state_r <= S_RESULT;
          end else begin
            pr_idx_r <= pr_idx_r + SW'(1);
            state_r  <= S_PR_RD;
          end
        end
        S_PR_DST: begin
          state_r <= S_PR_WAIT;
        end
        S_PR_WAIT: begin
          if (dist_ov) begin
            if (far) begin
              vcnt_r    <= vcnt_r - vmap_pkg::VCNT_W'(1);
              pcnt_r    <= pcnt_r - vmap_pkg::PCNT_W'(pr_pts_r);
              removed_r <= removed_r + vmap_pkg::VCNT_W'(1);
            end
            if (&pr_idx_r) begin
              st_r    <= vmap_pkg::ST_PRUNED;
              state_r <= S_RESULT;
            end else begin
              pr_idx_r <= pr_idx_r + SW'(1);
              state_r  <= S_PR_RD;
            end
          end
        end
        S_RESULT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_st_r    <= st_r;
            out_rem_r   <= removed_r;
            out_occ_r   <= vcnt_r;
            out_tot_r   <= pcnt_r;
            clr_item_r  <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_st_r;
  assign out_tdata  = {4'b0, out_tot_r, out_occ_r, out_rem_r};

endmodule

FILE: hw/rtl/vmap_checker.sv
`timescale 1ns / 1ps
module vmap_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic [2:0]  out_tuser
);

  // a waiting result is held
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result dropped or changed while stalled");

  // only a prune reports removed voxels
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != vmap_pkg::ST_PRUNED |-> out_tdata[12:0] == 13'd0)
    else $error("removed count on a non-prune result");

  // a clear leaves nothing behind
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == vmap_pkg::ST_CLEARED |->
      out_tdata[25:13] == 13'd0 && out_tdata[43:26] == 18'd0)
    else $error("counts not zero after clear");

  // a new voxel always leaves at least one voxel and one point
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == vmap_pkg::ST_NEW_VOXEL |->
      out_tdata[25:13] != 13'd0 && out_tdata[43:26] != 18'd0)
    else $error("empty counts after new voxel");

endmodule

bind voxel_map_point_insert_prune vmap_checker u_vmap_checker (
  .clk(clk), .rst_n(rst_n), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .out_tuser(out_tuser)
);
